FILE: design/utf8_to_utf16_transcoder_defines.svh
// Assertion macros used by the transcoder top level.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define U2U_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define U2U_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/u2u_pkg.sv
// Types and constants for the UTF-8 to UTF-16 transcoder.
package u2u_pkg;

	// Kind of multi-byte sequence in progress
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_TWO   = 2'd1,
		KIND_THREE = 2'd2,
		KIND_FOUR  = 2'd3
	} seq_kind_t;

	// Byte classification
	localparam logic [1:0] CONT_TAG   = 2'b10;
	localparam logic [7:0] ASCII_TOP  = 8'h7F;
	localparam logic [7:0] LEAD_TWO   = 8'hC2;
	localparam logic [7:0] LEAD_THREE = 8'hE0;
	localparam logic [7:0] LEAD_FOUR  = 8'hF0;

	// Code point ranges
	localparam logic [21:0] CP_MIN_THREE = 22'h000800;
	localparam logic [21:0] SURR_LO      = 22'h00D800;
	localparam logic [21:0] SURR_HI      = 22'h00DFFF;
	localparam logic [21:0] CP_MIN_FOUR  = 22'h010000;
	localparam logic [21:0] CP_LIMIT     = 22'h110000;

	// Surrogate pair construction
	localparam logic [15:0] HIGH_OFFSET = 16'hD7C0;
	localparam logic [15:0] LOW_BASE    = 16'hDC00;

	// Counter and capacity
	localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
	localparam logic [31:0] CAP_RESET    = 32'hFFFF_FFFF;
	localparam int          SLOTS        = 3;

	// One result item
	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_item;
		logic [31:0] unit_total;
		logic        run_last;
	} result_t;

	// All results caused by one byte, in output order
	typedef struct packed {
		result_t [SLOTS-1:0] slot;
		logic    [SLOTS-1:0] valid;
	} bundle_t;

endpackage

FILE: design/u2u_decode.sv
// Decoder: sequence state, unit counter, capacity register and result bundle.
module u2u_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             out_capacity_we,
	input  logic [31:0]      out_capacity,
	input  logic             in_fire,
	input  logic [7:0]       in_byte,
	input  logic             last_byte,
	output u2u_pkg::bundle_t bundle
);

	logic [31:0]         out_capacity_q;
	logic [1:0]          pend_q, pend_d;
	u2u_pkg::seq_kind_t  kind_q, kind_d;
	logic [20:0]         part_q, part_d;
	logic [31:0]         count_q, count_d;

	logic [21:0] acc_v;
	logic [15:0] hi_sum;
	logic        is_cont;
	logic        emit_a, emit_b;
	logic [15:0] unit_a, unit_b;
	logic [31:0] limit, cnt_a, cnt_b;
	logic        fits_a, fits_b;

	assign is_cont = (in_byte[7:6] == u2u_pkg::CONT_TAG);
	assign acc_v   = {part_q[15:0], in_byte[5:0]};
	assign hi_sum  = {4'b0000, acc_v[21:10]} + u2u_pkg::HIGH_OFFSET;

	// Decode the byte against the pending sequence
	always_comb begin
		pend_d = pend_q;
		kind_d = kind_q;
		part_d = part_q;
		emit_a = 1'b0;
		emit_b = 1'b0;
		unit_a = '0;
		unit_b = '0;
		if (pend_q != 2'd0 && is_cont) begin
			pend_d = pend_q - 2'd1;
			if (pend_d != 2'd0) begin
				part_d = acc_v[20:0];
			end else begin
				kind_d = u2u_pkg::KIND_NONE;
				part_d = '0;
				case (kind_q)
					u2u_pkg::KIND_TWO: begin
						emit_a = 1'b1;
						unit_a = acc_v[15:0];
					end
					u2u_pkg::KIND_THREE: begin
						if (acc_v >= u2u_pkg::CP_MIN_THREE &&
						    !(acc_v inside {[u2u_pkg::SURR_LO:u2u_pkg::SURR_HI]})) begin
							emit_a = 1'b1;
							unit_a = acc_v[15:0];
						end
					end
					default: begin
						if (acc_v >= u2u_pkg::CP_MIN_FOUR && acc_v < u2u_pkg::CP_LIMIT) begin
							emit_a = 1'b1;
							emit_b = 1'b1;
							unit_a = hi_sum;
							unit_b = u2u_pkg::LOW_BASE | {6'b000000, acc_v[9:0]};
						end
					end
				endcase
			end
		end else begin
			// drop any pending sequence and treat the byte as a lead
			pend_d = 2'd0;
			kind_d = u2u_pkg::KIND_NONE;
			part_d = '0;
			if (in_byte <= u2u_pkg::ASCII_TOP) begin
				emit_a = 1'b1;
				unit_a = {8'h00, in_byte};
			end else if (in_byte inside {[u2u_pkg::LEAD_TWO:8'hDF]}) begin
				kind_d = u2u_pkg::KIND_TWO;
				pend_d = 2'd1;
				part_d = {16'h0000, in_byte[4:0]};
			end else if (in_byte inside {[u2u_pkg::LEAD_THREE:8'hEF]}) begin
				kind_d = u2u_pkg::KIND_THREE;
				pend_d = 2'd2;
				part_d = {17'h00000, in_byte[3:0]};
			end else if (in_byte >= u2u_pkg::LEAD_FOUR) begin
				kind_d = u2u_pkg::KIND_FOUR;
				pend_d = 2'd3;
				part_d = {17'h00000, in_byte[3:0]};
			end
		end
		// end of stream drops any truncated sequence
		if (last_byte) begin
			pend_d = 2'd0;
			kind_d = u2u_pkg::KIND_NONE;
			part_d = '0;
		end
	end

	// Count units and decide which fit below the reserved terminator slot
	always_comb begin
		limit   = (out_capacity_q == 32'd0) ? 32'd0 : out_capacity_q - 32'd1;
		fits_a  = count_q < limit;
		cnt_a   = (emit_a && count_q != u2u_pkg::COUNT_MAX) ? count_q + 32'd1 : count_q;
		fits_b  = cnt_a < limit;
		cnt_b   = (emit_b && cnt_a != u2u_pkg::COUNT_MAX) ? cnt_a + 32'd1 : cnt_a;
		count_d = last_byte ? 32'd0 : cnt_b;
	end

	// Build the result bundle in output order
	always_comb begin
		bundle.valid[0]            = emit_a && fits_a;
		bundle.slot[0].code_unit   = unit_a;
		bundle.slot[0].end_item    = 1'b0;
		bundle.slot[0].unit_total  = cnt_a;
		bundle.valid[1]            = emit_b && fits_b;
		bundle.slot[1].code_unit   = unit_b;
		bundle.slot[1].end_item    = 1'b0;
		bundle.slot[1].unit_total  = cnt_b;
		bundle.valid[2]            = last_byte;
		bundle.slot[2].code_unit   = 16'h0000;
		bundle.slot[2].end_item    = 1'b1;
		bundle.slot[2].unit_total  = cnt_b;
		bundle.slot[2].run_last    = 1'b1;
		bundle.slot[1].run_last    = !last_byte;
		bundle.slot[0].run_last    = !last_byte && !bundle.valid[1];
	end

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= u2u_pkg::CAP_RESET;
		end else if (out_capacity_we) begin
			out_capacity_q <= out_capacity;
		end
	end

	// Advance the sequence state and counter on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			kind_q  <= u2u_pkg::KIND_NONE;
			part_q  <= '0;
			count_q <= '0;
		end else if (in_fire) begin
			pend_q  <= pend_d;
			kind_q  <= kind_d;
			part_q  <= part_d;
			count_q <= count_d;
		end
	end

endmodule

FILE: design/u2u_outbuf.sv
// Result register: holds one byte's results and hands them out one at a time.
module u2u_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  u2u_pkg::bundle_t bundle,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             load_ok,
	output u2u_pkg::result_t head
);

	u2u_pkg::result_t [u2u_pkg::SLOTS-1:0] slot_s1;
	logic [u2u_pkg::SLOTS-1:0]             valid_s1;

	assign out_valid = |valid_s1;
	// free now, or the only remaining result leaves this cycle
	assign load_ok   = !out_valid || (out_ready && $onehot(valid_s1));

	// Select the oldest remaining result
	always_comb begin
		if (valid_s1[0]) begin
			head = slot_s1[0];
		end else if (valid_s1[1]) begin
			head = slot_s1[1];
		end else begin
			head = slot_s1[2];
		end
	end

	// Load a new bundle, or drop the result just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= '0;
		end else if (in_fire) begin
			valid_s1 <= bundle.valid;
		end else if (out_valid && out_ready) begin
			valid_s1 <= valid_s1 & (valid_s1 - 3'd1);
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_s1 <= bundle.slot;
		end
	end

endmodule

FILE: design/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder: one byte in per transaction, code units out.
// Results are registered: a byte's first result appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and out_ready is high;
// a byte giving a surrogate pair and/or an end item holds input until its last result is being taken.
// Reset: sequence state and unit count clear, capacity returns to FFFFFFFF.
`include "utf8_to_utf16_transcoder_defines.svh"

module utf8_to_utf16_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_capacity_we,
	input  logic [31:0] out_capacity,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        end_item,
	output logic [31:0] unit_total,
	output logic        run_last
);

	u2u_pkg::bundle_t bundle;
	u2u_pkg::result_t head;
	logic             in_fire;

	assign in_fire = in_valid && in_ready;

	// Decode the accepted byte
	u2u_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.out_capacity_we (out_capacity_we),
		.out_capacity    (out_capacity),
		.in_fire         (in_fire),
		.in_byte         (in_byte),
		.last_byte       (last_byte),
		.bundle          (bundle)
	);

	// Register and serialise its results
	u2u_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.bundle    (bundle),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.load_ok   (in_ready),
		.head      (head)
	);

	assign code_unit  = head.code_unit;
	assign end_item   = head.end_item;
	assign unit_total = head.unit_total;
	assign run_last   = head.run_last;

	`U2U_ASSERT_NOW(a_empty_takes_input, !out_valid, in_ready, "input stalled with no result held")
	`U2U_ASSERT_NOW(a_overlap_on_final, out_valid && in_ready, out_ready && run_last, "byte accepted over undelivered results")
	`U2U_ASSERT_NOW(a_end_item_form, out_valid && end_item, code_unit == 16'h0000 && run_last, "malformed end item")

endmodule
